### rtl/rrct_pkg.sv
// ----------------------------------------------------------------------------
// rrct_pkg
// Types shared by the round-robin completion-time block and its channels.
// ----------------------------------------------------------------------------
package rrct_pkg;

    localparam int TIME_W  = 24;
    localparam int VALUE_W = 28;
    localparam int FIELD_W = 16;
    localparam int INDEX_W = 4;

    typedef struct packed {
        logic [FIELD_W-1:0] arrival_time;
        logic [FIELD_W-1:0] burst_time;
        logic               last_process;
    } rrct_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0]        process_index;
        logic                      is_totals;
        logic signed [VALUE_W-1:0] turnaround_value;
        logic signed [VALUE_W-1:0] waiting_value;
        logic                      last_result;
    } rrct_out_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_READ,
        S_CHECK,
        S_ADDQ,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_FIN4,
        S_FIN5,
        S_EMIT,
        S_NEXT,
        S_CMP,
        S_TOTAL
    } rrct_state_t;

endpackage

### rtl/rrct_if.sv
// ----------------------------------------------------------------------------
// rrct_in_if / rrct_out_if
// Valid/ready channels for process loads and for completion records.
// ----------------------------------------------------------------------------
interface rrct_in_if;
    import rrct_pkg::*;

    logic     valid;
    logic     ready;
    rrct_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rrct_out_if;
    import rrct_pkg::*;

    logic      valid;
    logic      ready;
    rrct_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/round_robin_completion_times_top.sv
// ----------------------------------------------------------------------------
// round_robin_completion_times_top
// Loads up to MAX_PROCESSES processes one beat each; the beat marked last runs
// a round-robin schedule on one shared 28-bit add/subtract unit.
// Load: beats are taken only while loading; the last beat starts the run.
// Run: each visit tests the remaining time against the quantum, then cuts it
// by a slice or completes it and emits a record, waiting out any output stall;
// a totals beat ends the run. Loads resume right after totals.
// Reset (rst_n, async low) clears control state and sets the quantum to 1;
// the process stores hold whatever they held until a batch writes them.
// ----------------------------------------------------------------------------
module round_robin_completion_times_top #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [rrct_pkg::FIELD_W-1:0] cfg_wr_data,
    rrct_in_if.sink                   load,
    rrct_out_if.source                result
);
    import rrct_pkg::*;

    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    // process stores
    logic [FIELD_W-1:0] arrival_mem   [MAX_PROCESSES];
    logic [FIELD_W-1:0] burst_mem     [MAX_PROCESSES];
    logic [FIELD_W-1:0] remaining_mem [MAX_PROCESSES];
    logic [FIELD_W-1:0] arr_rd_reg;
    logic [FIELD_W-1:0] bur_rd_reg;
    logic [FIELD_W-1:0] rem_rd_reg;

    rrct_state_t state_reg, state_next;

    logic [FIELD_W-1:0]     quantum_reg;
    logic [FIELD_W-1:0]     q_eff;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       unfin_reg, unfin_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [VALUE_W-1:0]     tsum_reg, tsum_next;
    logic [VALUE_W-1:0]     wsum_reg, wsum_next;
    logic [VALUE_W-1:0]     ta_reg, ta_next;
    logic [VALUE_W-1:0]     wt_reg, wt_next;
    logic                   worked_reg, worked_next;
    logic [MAX_PROCESSES-1:0] finished_reg, finished_next;

    logic      out_valid_reg;
    rrct_out_t out_data_reg;
    rrct_out_t out_data_next;
    logic      out_load;
    logic      slot_free;

    // memory control
    logic               load_we;
    logic               rem_we;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rem_addr;
    logic [FIELD_W-1:0] rem_wdata;
    logic               arr_rd_en;
    logic [IDX_W-1:0]   arr_addr;
    logic               rd_en;

    // shared add/subtract unit
    logic [VALUE_W-1:0] alu_a;
    logic [VALUE_W-1:0] alu_b;
    logic               alu_sub;
    logic [VALUE_W:0]   alu_sum;
    logic [VALUE_W-1:0] alu_res;
    logic               no_borrow;
    logic               r_le_q;

    logic             accept;
    logic             full;
    logic [CNT_W-1:0] idx_inc;
    logic             wrap;

    assign q_eff     = (quantum_reg == '0) ? FIELD_W'(1) : quantum_reg;
    assign accept    = load.valid && load.ready;
    assign full      = (count_reg >= CNT_W'(MAX_PROCESSES));
    assign wr_addr   = count_reg[IDX_W-1:0];
    assign idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);
    assign wrap      = (idx_inc >= count_reg);
    assign slot_free = !out_valid_reg || result.ready;

    assign load.ready   = (state_reg == S_LOAD);
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ALU operand select
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_CHECK:
            begin
                alu_a   = VALUE_W'(rem_rd_reg);
                alu_b   = VALUE_W'(q_eff);
                alu_sub = 1'b1;
            end
            S_ADDQ:
            begin
                alu_a = VALUE_W'(time_reg);
                alu_b = VALUE_W'(q_eff);
            end
            S_FIN1:
            begin
                alu_a = VALUE_W'(time_reg);
                alu_b = VALUE_W'(rem_rd_reg);
            end
            S_FIN2, S_CMP:
            begin
                alu_a   = VALUE_W'(time_reg);
                alu_b   = VALUE_W'(arr_rd_reg);
                alu_sub = 1'b1;
            end
            S_FIN3:
            begin
                alu_a   = ta_reg;
                alu_b   = VALUE_W'(bur_rd_reg);
                alu_sub = 1'b1;
            end
            S_FIN4:
            begin
                alu_a = tsum_reg;
                alu_b = ta_reg;
            end
            S_FIN5:
            begin
                alu_a = wsum_reg;
                alu_b = wt_reg;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (VALUE_W+1)'(alu_sub);
    assign alu_res   = alu_sum[VALUE_W-1:0];
    assign no_borrow = alu_sum[VALUE_W];
    assign r_le_q    = !no_borrow || (alu_res == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    state_next = load.data.last_process ? S_INIT : S_LOAD;
                end
            end
            S_INIT:  state_next = S_READ;
            S_READ:  state_next = S_CHECK;
            S_CHECK:
            begin
                if (finished_reg[idx_reg])
                begin
                    state_next = S_NEXT;
                end
                else if (r_le_q)
                begin
                    state_next = S_FIN1;
                end
                else
                begin
                    state_next = S_ADDQ;
                end
            end
            S_ADDQ:  state_next = S_NEXT;
            S_FIN1:  state_next = S_FIN2;
            S_FIN2:  state_next = S_FIN3;
            S_FIN3:  state_next = S_FIN4;
            S_FIN4:  state_next = S_FIN5;
            S_FIN5:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (!wrap)
                begin
                    state_next = S_CMP;
                end
                else if (unfin_reg == '0)
                begin
                    state_next = S_TOTAL;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_CMP:   state_next = (unfin_reg == '0) ? S_TOTAL : S_READ;
            S_TOTAL:
            begin
                if (slot_free)
                begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next    = count_reg;
        unfin_next    = unfin_reg;
        time_next     = time_reg;
        idx_next      = idx_reg;
        tsum_next     = tsum_reg;
        wsum_next     = wsum_reg;
        ta_next       = ta_reg;
        wt_next       = wt_reg;
        worked_next   = worked_reg;
        finished_next = finished_reg;
        out_load      = 1'b0;
        out_data_next = out_data_reg;
        load_we       = 1'b0;
        rem_we        = 1'b0;
        rem_addr      = wr_addr;
        rem_wdata     = load.data.burst_time;
        arr_rd_en     = 1'b0;
        arr_addr      = idx_reg;
        rd_en         = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                if (accept && !full)
                begin
                    load_we    = 1'b1;
                    rem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_INIT:
            begin
                finished_next = '0;
                time_next     = '0;
                idx_next      = '0;
                unfin_next    = count_reg;
            end
            S_READ:
            begin
                arr_rd_en = 1'b1;
                rd_en     = 1'b1;
            end
            S_CHECK:
            begin
                worked_next = !finished_reg[idx_reg];
                if (!finished_reg[idx_reg] && !r_le_q)
                begin
                    // cut the process by one slice
                    rem_we    = 1'b1;
                    rem_addr  = idx_reg;
                    rem_wdata = alu_res[FIELD_W-1:0];
                end
            end
            S_ADDQ, S_FIN1:
            begin
                time_next = alu_res[TIME_W-1:0];
            end
            S_FIN2:
            begin
                ta_next                = alu_res;
                finished_next[idx_reg] = 1'b1;
                unfin_next             = unfin_reg - CNT_W'(1);
            end
            S_FIN3:  wt_next   = alu_res;
            S_FIN4:  tsum_next = alu_res;
            S_FIN5:  wsum_next = alu_res;
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_load                       = 1'b1;
                    out_data_next.process_index    = INDEX_W'(idx_reg);
                    out_data_next.is_totals        = 1'b0;
                    out_data_next.turnaround_value = ta_reg;
                    out_data_next.waiting_value    = wt_reg;
                    out_data_next.last_result      = 1'b0;
                end
            end
            S_NEXT:
            begin
                if (wrap)
                begin
                    idx_next = '0;
                end
                else
                begin
                    arr_rd_en = 1'b1;
                    arr_addr  = idx_inc[IDX_W-1:0];
                end
            end
            S_CMP:
            begin
                if (no_borrow)
                begin
                    idx_next = idx_inc[IDX_W-1:0];
                end
                else if (!worked_reg)
                begin
                    // idle processor: jump time to the next arrival
                    time_next = TIME_W'(arr_rd_reg);
                    idx_next  = idx_inc[IDX_W-1:0];
                end
                else
                begin
                    idx_next = '0;
                end
            end
            S_TOTAL:
            begin
                if (slot_free)
                begin
                    out_load                       = 1'b1;
                    out_data_next.process_index    = '0;
                    out_data_next.is_totals        = 1'b1;
                    out_data_next.turnaround_value = tsum_reg;
                    out_data_next.waiting_value    = wsum_reg;
                    out_data_next.last_result      = 1'b1;
                    count_next                     = '0;
                    unfin_next                     = '0;
                    time_next                      = '0;
                    idx_next                       = '0;
                    tsum_next                      = '0;
                    wsum_next                      = '0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // stores and registered reads
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            arrival_mem[wr_addr] <= load.data.arrival_time;
            burst_mem[wr_addr]   <= load.data.burst_time;
        end
        if (rem_we)
        begin
            remaining_mem[rem_addr] <= rem_wdata;
        end
        if (arr_rd_en)
        begin
            arr_rd_reg <= arrival_mem[arr_addr];
        end
        if (rd_en)
        begin
            bur_rd_reg <= burst_mem[idx_reg];
            rem_rd_reg <= remaining_mem[idx_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ta_reg <= ta_next;
        wt_reg <= wt_next;
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            quantum_reg   <= FIELD_W'(1);
            count_reg     <= '0;
            unfin_reg     <= '0;
            time_reg      <= '0;
            idx_reg       <= '0;
            tsum_reg      <= '0;
            wsum_reg      <= '0;
            worked_reg    <= 1'b0;
            finished_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            unfin_reg    <= unfin_next;
            time_reg     <= time_next;
            idx_reg      <= idx_next;
            tsum_reg     <= tsum_next;
            wsum_reg     <= wsum_next;
            worked_reg   <= worked_next;
            finished_reg <= finished_next;
            if (cfg_wr_en)
            begin
                quantum_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // checks
    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (unfin_reg == '0 && time_reg == '0 && tsum_reg == '0))
        else $error("run state not cleared while loading");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(MAX_PROCESSES)) && (unfin_reg <= count_reg))
        else $error("process counts out of range");

    a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN2) |-> !finished_reg[idx_reg])
        else $error("process completed twice");

endmodule

### tb/sv/rrct_completion_checker.sv
// ----------------------------------------------------------------------------
// rrct_completion_checker
// Watches the load, result and quantum ports of the round-robin block, runs
// its own round-robin schedule for every batch that a last beat closes, and
// compares each result beat, field by field, with the oldest completion
// record still owed. Failures are counted and handed back to the bench top.
// ----------------------------------------------------------------------------
module rrct_completion_checker #(
    parameter int MAX_PROCS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [rrct_pkg::FIELD_W-1:0] cfg_wr_data,
    rrct_in_if                           load_mon,
    rrct_out_if                          result_mon,
    output int                           fail_count,
    output int                           pending
);
    import rrct_pkg::*;

    logic [FIELD_W-1:0] slice_cfg;
    logic [FIELD_W-1:0] arrival_tab [MAX_PROCS];
    logic [FIELD_W-1:0] burst_tab [MAX_PROCS];
    int unsigned        loaded;
    rrct_out_t          completion_q [$];

    function automatic rrct_out_t make_record(input logic [INDEX_W-1:0] idx,
                                              input logic totals,
                                              input logic [VALUE_W-1:0] ta,
                                              input logic [VALUE_W-1:0] wt,
                                              input logic last);
        rrct_out_t rec;
        rec.process_index    = idx;
        rec.is_totals        = totals;
        rec.turnaround_value = ta;
        rec.waiting_value    = wt;
        rec.last_result      = last;
        return rec;
    endfunction

    // Run the whole schedule for the loaded batch and queue its records.
    task automatic predict_schedule();
        logic [FIELD_W-1:0] left [MAX_PROCS];
        bit                 done [MAX_PROCS];
        logic [TIME_W-1:0]  now;
        logic [VALUE_W-1:0] ta;
        logic [VALUE_W-1:0] wt;
        logic [VALUE_W-1:0] ta_sum;
        logic [VALUE_W-1:0] wt_sum;
        int unsigned        slice;
        int unsigned        idx;
        int unsigned        p;
        int unsigned        open_cnt;
        bit                 worked;

        slice    = (slice_cfg == '0) ? 1 : int'(slice_cfg);
        now      = '0;
        idx      = 0;
        ta_sum   = '0;
        wt_sum   = '0;
        open_cnt = loaded;
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            done[i] = 1'b0;
            left[i] = burst_tab[i];
        end

        while (open_cnt != 0)
        begin
            p      = idx;
            worked = 1'b0;
            if (!done[p])
            begin
                worked = 1'b1;
                if (left[p] <= slice)
                begin
                    now      = now + TIME_W'(left[p]);
                    left[p]  = '0;
                    done[p]  = 1'b1;
                    open_cnt = open_cnt - 1;
                    ta       = VALUE_W'(now) - VALUE_W'(arrival_tab[p]);
                    wt       = ta - VALUE_W'(burst_tab[p]);
                    ta_sum   = ta_sum + ta;
                    wt_sum   = wt_sum + wt;
                    completion_q.push_back(make_record(INDEX_W'(p), 1'b0, ta, wt, 1'b0));
                end
                else
                begin
                    left[p] = left[p] - FIELD_W'(slice);
                    now     = now + TIME_W'(slice);
                end
            end
            // Advance only to an arrived neighbor; jump the clock when idle.
            if (p + 1 >= loaded)
                idx = 0;
            else if (TIME_W'(arrival_tab[p + 1]) <= now)
                idx = p + 1;
            else if (!worked)
            begin
                now = TIME_W'(arrival_tab[p + 1]);
                idx = p + 1;
            end
            else
                idx = 0;
        end

        completion_q.push_back(make_record('0, 1'b1, ta_sum, wt_sum, 1'b1));
        loaded = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rrct_out_t want;
        rrct_out_t got;

        if (!rst_n)
        begin
            slice_cfg = 16'd1;
            loaded    = 0;
            completion_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
                slice_cfg = cfg_wr_data;

            if (result_mon.valid && result_mon.ready)
            begin
                got = result_mon.data;
                if (completion_q.size() == 0)
                begin
                    fail_count++;
                    $display({"%0t: unexpected result beat",
                              " idx=%0d tot=%0b ta=%0d wt=%0d last=%0b"},
                             $time, got.process_index, got.is_totals,
                             got.turnaround_value, got.waiting_value, got.last_result);
                end
                else
                begin
                    want = completion_q.pop_front();
                    if (got.process_index !== want.process_index ||
                        got.is_totals !== want.is_totals ||
                        got.turnaround_value !== want.turnaround_value ||
                        got.waiting_value !== want.waiting_value ||
                        got.last_result !== want.last_result)
                    begin
                        fail_count++;
                        $display({"%0t: result mismatch: expected",
                                  " idx=%0d tot=%0b ta=%0d wt=%0d last=%0b"},
                                 $time, want.process_index, want.is_totals,
                                 want.turnaround_value, want.waiting_value,
                                 want.last_result);
                        $display({"%0t:                  actual",
                                  " idx=%0d tot=%0b ta=%0d wt=%0d last=%0b"},
                                 $time, got.process_index, got.is_totals,
                                 got.turnaround_value, got.waiting_value,
                                 got.last_result);
                    end
                end
            end

            if (load_mon.valid && load_mon.ready)
            begin
                // Drop loads past a full store; a last beat still starts the run.
                if (loaded < MAX_PROCS)
                begin
                    arrival_tab[loaded] = load_mon.data.arrival_time;
                    burst_tab[loaded]   = load_mon.data.burst_time;
                    loaded              = loaded + 1;
                end
                if (load_mon.data.last_process)
                    predict_schedule();
            end

            pending = completion_q.size();
        end
    end

endmodule

### tb/sv/tb_round_robin_completion_times_top.sv
// ----------------------------------------------------------------------------
// tb_round_robin_completion_times_top
// Drives batches of process loads into the round-robin block under several
// quantum settings: a directed opening (reset quantum, early start, zero
// quantum, zero burst, idle time jump, maximal bursts, a full store with
// dropped loads) and then random batches. Both channels idle at random; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_round_robin_completion_times_top;
    import rrct_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned ITEM_TARGET   = 310;
    localparam int unsigned PHASES        = 9;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [FIELD_W-1:0] cfg_wr_data;
    int                 fail_count;
    int                 pending;

    bit          quiet;
    bit          rx_hold_req;
    bit          rx_hold_done;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned items_sent;
    int unsigned cur_slice;
    int unsigned cycle_count;

    rrct_in_if  load_ch ();
    rrct_out_if result_ch ();

    round_robin_completion_times_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .load        (load_ch),
        .result      (result_ch)
    );

    rrct_completion_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .load_mon    (load_ch),
        .result_mon  (result_ch),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("round_robin_completion_times_top test failed");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        result_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (rx_hold_req && !rx_hold_done)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < rx_idle_pct)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    task automatic send_item(input logic [FIELD_W-1:0] arr, input logic [FIELD_W-1:0] bst,
                             input logic last);
        int unsigned gap;

        if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 12);
            load_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        load_ch.valid             <= 1'b1;
        load_ch.data.arrival_time <= arr;
        load_ch.data.burst_time   <= bst;
        load_ch.data.last_process <= last;
        do
            @(posedge clk);
        while (!load_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_slice(input logic [FIELD_W-1:0] q);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= q;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_slice = (q == '0) ? 1 : int'(q);
    endtask

    // Hold the load side until every owed record is back, then let it settle.
    task automatic drain_results();
        load_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One batch: bursts of up to four slices, arrivals in one of several shapes.
    task automatic send_batch(input int unsigned n);
        int unsigned shape;
        int unsigned bmax;
        int unsigned span;
        int unsigned a;
        int unsigned b;

        shape = $urandom_range(0, 3);
        bmax  = (cur_slice * 4 > 65535) ? 65535 : cur_slice * 4;
        span  = (shape == 3) ? bmax * 8 : bmax;
        a     = 0;
        for (int i = 0; i < n; i++)
        begin
            b = ($urandom_range(0, 39) == 0) ? 0 : $urandom_range(1, bmax);
            case (shape)
                0:       a = 0;
                2:       a = $urandom_range(0, 65535);
                default: if (i > 0) a = a + $urandom_range(0, span);
            endcase
            if (a > 65535)
                a = 65535;
            send_item(FIELD_W'(a), FIELD_W'(b), i == n - 1);
        end
    endtask

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 25;
        endcase
    endfunction

    initial
    begin
        int unsigned qv;
        int unsigned budget;
        int unsigned r;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        load_ch.valid = 1'b0;
        load_ch.data  = '0;
        quiet         = 1'b0;
        rx_hold_req   = 1'b0;
        rx_hold_done  = 1'b0;
        tx_idle_pct   = 10;
        rx_idle_pct   = 10;
        items_sent    = 0;
        cur_slice     = 1;
        cycle_count   = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Quantum still at its reset value.
        send_item(16'd0, 16'd3, 1'b1);
        drain_results();
        // Late process 0 served from time 0: negative turnaround and waiting.
        send_item(16'hFFFF, 16'd1, 1'b1);
        drain_results();
        // Zero quantum acts as one; idle jump to a late arrival with zero burst.
        write_slice(16'd0);
        send_item(16'd0, 16'd2, 1'b0);
        send_item(16'hFFFF, 16'd0, 1'b1);
        drain_results();
        write_slice(16'hFFFF);
        send_item(16'd0, 16'hFFFF, 1'b0);
        send_item(16'd0, 16'hFFFF, 1'b1);
        drain_results();
        // Overfill the store under a long result hold-off; keep offering beats.
        write_slice(16'd3);
        rx_hold_req = 1'b1;
        for (int i = 0; i < 18; i++)
            send_item(FIELD_W'(i * 2), FIELD_W'(1 + i % 7), i == 17);
        send_batch(3);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
                qv = 1;
            else if (ph == 1)
                qv = 65535;
            else if (ph % 2 == 0)
                qv = $urandom_range(1, 16);
            else
                qv = $urandom_range(17, 65535);
            write_slice(FIELD_W'(qv));
            quiet       = (ph == PHASES - 1);
            tx_idle_pct = pick_idle_pct();
            rx_idle_pct = pick_idle_pct();
            budget = items_sent;
            if (ITEM_TARGET > items_sent)
                budget = items_sent + (ITEM_TARGET - items_sent) / (PHASES - ph);
            while (items_sent < budget)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    send_batch($urandom_range(17, 20));
                else if (r < 4)
                    send_batch($urandom_range(7, 16));
                else
                    send_batch($urandom_range(1, 6));
            end
            drain_results();
        end

        if (fail_count == 0)
            $display("round_robin_completion_times_top test passed");
        else
            $display("round_robin_completion_times_top test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/rrct_pkg.sv
rtl/rrct_if.sv
rtl/round_robin_completion_times_top.sv
tb/sv/rrct_completion_checker.sv
tb/sv/tb_round_robin_completion_times_top.sv
